// ----- sv/life_automaton_torus_unit_assert.svh -----
// Assertion macros for the toroidal life grid block.
// Taken in by life_automaton_torus_unit.sv; expects clk and rst_n in scope.
`ifndef LIFE_AUTOMATON_TORUS_UNIT_ASSERT_SVH
`define LIFE_AUTOMATON_TORUS_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define LAT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/lat_pkg.sv -----
// Shared types and constants for the toroidal life grid block.
// No dependencies; used by life_automaton_torus_unit.
`default_nettype none

package lat_pkg;

    localparam int OP_W  = 2;
    localparam int ROW_W = 6;
    localparam int COL_W = 7;
    localparam int NBR_W = 4;

    // Neighbor counts of the life rule.
    localparam logic [NBR_W-1:0] KEEP_COUNT  = 4'd2;
    localparam logic [NBR_W-1:0] BIRTH_COUNT = 4'd3;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_ADVANCE = 2'd3
    } op_t;

endpackage

`default_nettype wire

// ----- sv/lat_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module lat_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- sv/life_automaton_torus_unit.sv -----
// Toroidal life grid: input channel (op, row, col, cell_in), output channel (cell_out).
// The grid has one row per RAM word; each beat asks for write, read, clear or advance.
// Every accepted input beat yields exactly one output beat; cell_out is the cell's
// value for a read and 0 for all other operations (and for coordinates off the grid).
// A cell write or read passes S_RW_RD and S_RW_DONE, a clear sweeps every row in S_CLEAR,
// a generation passes S_GEN_LOAD0 to S_GEN_LOAD2, then S_GEN_RD and S_GEN_WR per row;
// each then waits in S_FINISH until the output register is free. in_ready rises with
// out_valid, so the next item can be taken as soon as the result is offered.
// A generation reads one old row in S_GEN_RD and writes one new row in S_GEN_WR through
// the single row RAM port pair; a row-wide rule unit computes each new row at once.
// One item is worked on at a time: in_ready is high only while the sequencer waits.
// The finished result sits in an output register, so the next input beat is taken
// even while the receiver stalls; the item after that waits for the register to drain.
// After reset the block sweeps the grid to zero, one row a cycle, with in_ready low;
// no output beat comes from that sweep.
// Depends on lat_pkg, lat_ram and life_automaton_torus_unit_assert.svh.
`default_nettype none

`include "life_automaton_torus_unit_assert.svh"

module life_automaton_torus_unit #(
    parameter int GRID_COLS = 128,
    parameter int GRID_ROWS = 64
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [lat_pkg::OP_W-1:0]   op,
    input  wire logic [lat_pkg::ROW_W-1:0]  row,
    input  wire logic [lat_pkg::COL_W-1:0]  col,
    input  wire logic                       cell_in,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic                            cell_out
);

    localparam int RW = $clog2(GRID_ROWS);
    localparam int CW = $clog2(GRID_COLS);
    localparam logic [RW-1:0] LAST_ROW = RW'(GRID_ROWS - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RW_RD,
        S_RW_DONE,
        S_GEN_LOAD0,
        S_GEN_LOAD1,
        S_GEN_LOAD2,
        S_GEN_RD,
        S_GEN_WR,
        S_FINISH
    } state_t;

    state_t              state_reg;
    logic [RW-1:0]       row_cnt_reg;
    logic                reply_reg;
    logic                out_valid_reg;
    logic                cell_out_reg;

    lat_pkg::op_t        op_reg;
    logic [RW-1:0]       addr_reg;
    logic [CW-1:0]       col_reg;
    logic                inside_reg;
    logic                val_reg;
    logic                res_reg;
    logic [GRID_COLS-1:0] first_reg;
    logic [GRID_COLS-1:0] above_reg;
    logic [GRID_COLS-1:0] here_reg;

    logic                 ram_we;
    logic [RW-1:0]        ram_waddr;
    logic [GRID_COLS-1:0] ram_wdata;
    logic [RW-1:0]        ram_raddr;
    logic [GRID_COLS-1:0] ram_rdata;

    logic                 accept;
    logic                 last_row;
    logic                 on_grid;
    logic [GRID_COLS-1:0] below;
    logic [GRID_COLS-1:0] new_row;
    logic [GRID_COLS-1:0] bit_mask;
    logic [GRID_COLS-1:0] merged_row;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign cell_out  = cell_out_reg;
    assign last_row  = (row_cnt_reg == LAST_ROW);
    assign on_grid   = (32'(row) < GRID_ROWS) && (32'(col) < GRID_COLS);

    // The bottom row wraps onto the old top row, kept aside before it was overwritten.
    assign below = last_row ? first_reg : ram_rdata;

    assign bit_mask   = GRID_COLS'(1) << col_reg;
    assign merged_row = (ram_rdata & ~bit_mask) | (val_reg ? bit_mask : '0);

    // Row-wide rule unit: every cell of the row from the three old rows around it.
    always_comb
    begin
        logic [GRID_COLS-1:0]    a_l, a_r, h_l, h_r, b_l, b_r;
        logic [lat_pkg::NBR_W-1:0] nsum;
        a_l = {above_reg[GRID_COLS-2:0], above_reg[GRID_COLS-1]};
        a_r = {above_reg[0], above_reg[GRID_COLS-1:1]};
        h_l = {here_reg[GRID_COLS-2:0], here_reg[GRID_COLS-1]};
        h_r = {here_reg[0], here_reg[GRID_COLS-1:1]};
        b_l = {below[GRID_COLS-2:0], below[GRID_COLS-1]};
        b_r = {below[0], below[GRID_COLS-1:1]};
        new_row = '0;
        for (int c = 0; c < GRID_COLS; c++)
        begin
            nsum = lat_pkg::NBR_W'(a_l[c]) + lat_pkg::NBR_W'(above_reg[c])
                 + lat_pkg::NBR_W'(a_r[c]) + lat_pkg::NBR_W'(h_l[c])
                 + lat_pkg::NBR_W'(h_r[c]) + lat_pkg::NBR_W'(b_l[c])
                 + lat_pkg::NBR_W'(below[c]) + lat_pkg::NBR_W'(b_r[c]);
            new_row[c] = (nsum == lat_pkg::BIRTH_COUNT)
                       || (here_reg[c] && (nsum == lat_pkg::KEEP_COUNT));
        end
    end

    // RAM port control, decoded from the sequencer state.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = row_cnt_reg;
        ram_wdata = '0;
        ram_raddr = addr_reg;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
            end
            S_RW_DONE:
            begin
                ram_we    = (op_reg == lat_pkg::OP_WRITE) && inside_reg;
                ram_waddr = addr_reg;
                ram_wdata = merged_row;
            end
            S_GEN_LOAD0:
            begin
                ram_raddr = '0;
            end
            S_GEN_LOAD1:
            begin
                ram_raddr = LAST_ROW;
            end
            S_GEN_RD:
            begin
                ram_raddr = last_row ? '0 : row_cnt_reg + RW'(1);
            end
            S_GEN_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = new_row;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    lat_ram #(
        .WIDTH (GRID_COLS),
        .DEPTH (GRID_ROWS)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            row_cnt_reg   <= '0;
            reply_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            cell_out_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    if (last_row)
                    begin
                        row_cnt_reg <= '0;
                        state_reg   <= reply_reg ? S_FINISH : S_IDLE;
                    end
                    else
                    begin
                        row_cnt_reg <= row_cnt_reg + RW'(1);
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        row_cnt_reg <= '0;
                        case (lat_pkg::op_t'(op))
                            lat_pkg::OP_WRITE,
                            lat_pkg::OP_READ:
                            begin
                                state_reg <= S_RW_RD;
                            end
                            lat_pkg::OP_CLEAR:
                            begin
                                reply_reg <= 1'b1;
                                state_reg <= S_CLEAR;
                            end
                            default:
                            begin
                                state_reg <= S_GEN_LOAD0;
                            end
                        endcase
                    end
                end
                S_RW_RD:     state_reg <= S_RW_DONE;
                S_RW_DONE:   state_reg <= S_FINISH;
                S_GEN_LOAD0: state_reg <= S_GEN_LOAD1;
                S_GEN_LOAD1: state_reg <= S_GEN_LOAD2;
                S_GEN_LOAD2: state_reg <= S_GEN_RD;
                S_GEN_RD:    state_reg <= S_GEN_WR;
                S_GEN_WR:
                begin
                    if (last_row)
                    begin
                        row_cnt_reg <= '0;
                        state_reg   <= S_FINISH;
                    end
                    else
                    begin
                        row_cnt_reg <= row_cnt_reg + RW'(1);
                        state_reg   <= S_GEN_RD;
                    end
                end
                S_FINISH:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        cell_out_reg  <= res_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Item latches and generation row buffers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= lat_pkg::op_t'(op);
            addr_reg   <= RW'(row);
            col_reg    <= CW'(col);
            inside_reg <= on_grid;
            val_reg    <= cell_in;
            res_reg    <= 1'b0;
        end
        if (state_reg == S_RW_DONE)
        begin
            res_reg <= (op_reg == lat_pkg::OP_READ) && inside_reg && ram_rdata[col_reg];
        end
        if (state_reg == S_GEN_LOAD1)
        begin
            first_reg <= ram_rdata;
            here_reg  <= ram_rdata;
        end
        if (state_reg == S_GEN_LOAD2)
        begin
            above_reg <= ram_rdata;
        end
        if (state_reg == S_GEN_WR)
        begin
            above_reg <= here_reg;
            here_reg  <= below;
        end
    end

    `LAT_ASSERT_SAME(a_idle_no_write, state_reg == S_IDLE, !ram_we, "grid written while idle")
    `LAT_ASSERT_NEXT(a_busy_after_beat, accept, !in_ready, "input taken while busy")
    `LAT_ASSERT_SAME(a_gen_row_range, state_reg == S_GEN_WR, 32'(row_cnt_reg) < GRID_ROWS, "generation row out of range")
    `LAT_ASSERT_SAME(a_zero_result, (state_reg == S_FINISH) && (op_reg != lat_pkg::OP_READ), !res_reg, "nonzero result for a non-read operation")

endmodule

`default_nettype wire
